// ===== sv/bpi_pkg.sv =====
// Shared types and constants for the bit set permutation image block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpi_pkg;

  localparam int SET_WORDS  = 4;
  localparam int WORD_BITS  = 64;
  localparam int WIDX_W     = $clog2(SET_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ELEM_W     = WIDX_W + BIT_W;
  localparam int PERM_DEPTH = 256;
  localparam int VAL_W      = 8;
  localparam int WC_W       = 3;
  localparam int OP_W       = 2;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_LOAD_PERM = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_APPLY     = 2'd2;

  typedef enum logic [1:0] {
    CMD_PERM,
    CMD_SET,
    CMD_APPLY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [VAL_W-1:0]       index;
    logic [VAL_W-1:0]       image_value;
    logic [WORD_BITS-1:0]   set_word;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN,
    BK_CHECK,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/bpi_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
// Depends on bpi_pkg.
`default_nettype none

module bpi_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [bpi_pkg::OP_W-1:0]     op_i,
  input  wire logic [bpi_pkg::VAL_W-1:0]    index_i,
  input  wire logic [bpi_pkg::VAL_W-1:0]    image_value_i,
  input  wire logic [bpi_pkg::WORD_BITS-1:0] set_word_i,
  output bpi_pkg::cmd_t                     q_head_o,
  output logic                              q_valid_o,
  input  wire logic                         q_pop_i
);
  import bpi_pkg::*;

  cmd_t              q_mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              keep;
  logic              push;
  logic              pop;
  cmd_t              cmd;

  // Classify: drop undefined ops and set loads beyond the store.
  always_comb begin
    cmd.index       = index_i;
    cmd.image_value = image_value_i;
    cmd.set_word    = set_word_i;
    cmd.kind        = CMD_PERM;
    keep            = 1'b0;
    case (op_i)
      OP_LOAD_PERM: begin
        cmd.kind = CMD_PERM;
        keep     = 1'b1;
      end
      OP_LOAD_SET: begin
        cmd.kind = CMD_SET;
        keep     = (index_i < VAL_W'(SET_WORDS));
      end
      OP_APPLY: begin
        cmd.kind = CMD_APPLY;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy      = (cnt_r == QCNT_W'(Q_DEPTH));
  assign push      = start && !busy && keep;
  assign q_valid_o = (cnt_r != '0);
  assign pop       = q_pop_i && q_valid_o;
  assign q_head_o  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bpi_back.sv =====
// Back end: permutation table, set store, image walk and result emission.
// Depends on bpi_pkg; fed by bpi_front's command queue.
`default_nettype none

module bpi_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bpi_pkg::WC_W-1:0]      word_count_i,
  input  wire bpi_pkg::cmd_t                 q_head_i,
  input  wire logic                          q_valid_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  output logic [bpi_pkg::WIDX_W-1:0]         out_word_index_o,
  output logic [bpi_pkg::WORD_BITS-1:0]      out_image_word_o,
  output logic                               out_maps_into_itself_o,
  output logic                               out_last_o
);
  import bpi_pkg::*;

  logic [VAL_W-1:0]     perm_mem [PERM_DEPTH];
  logic [WORD_BITS-1:0] set_r    [SET_WORDS];
  logic [WORD_BITS-1:0] image_r  [SET_WORDS];

  back_state_t          state_r, state_nxt;
  logic [WC_W-1:0]      wc_r;
  logic [WC_W-1:0]      wc_use;
  logic [ELEM_W-1:0]    e_r;
  logic [WIDX_W-1:0]    w_r;
  logic [VAL_W-1:0]     rd_r;
  logic                 pend_v_r;
  logic                 closed_r;

  logic                 out_valid_r;
  logic [WIDX_W-1:0]    out_word_index_r;
  logic [WORD_BITS-1:0] out_image_word_r;
  logic                 out_flag_r;
  logic                 out_last_r;

  logic                 elem_last;
  logic                 w_last;
  logic [WIDX_W-1:0]    set_addr;
  logic [WORD_BITS-1:0] set_rd;
  logic                 member;
  logic [WIDX_W-1:0]    img_word;
  logic [BIT_W-1:0]     img_bit;
  logic                 img_oor;
  logic                 do_perm_wr, do_set_wr, do_apply, do_proc, do_check, do_emit;

  // Clamp the configured word count into 1..SET_WORDS.
  always_comb begin
    if (word_count_i == '0) begin
      wc_use = WC_W'(1);
    end else if (word_count_i > WC_W'(SET_WORDS)) begin
      wc_use = WC_W'(SET_WORDS);
    end else begin
      wc_use = word_count_i;
    end
  end

  assign elem_last = (e_r[ELEM_W-1:BIT_W] == WIDX_W'(wc_r - WC_W'(1))) && (&e_r[BIT_W-1:0]);
  assign w_last    = (w_r == WIDX_W'(wc_r - WC_W'(1)));

  // One shared read address into the set store: element word while walking,
  // word counter while checking.
  assign set_addr  = (state_r == BK_WALK) ? e_r[ELEM_W-1:BIT_W] : w_r;
  assign set_rd    = set_r[set_addr];
  // MSB holds the lowest element, so bit 63-b is bit ~b.
  assign member    = set_rd[~e_r[BIT_W-1:0]];

  assign img_word  = rd_r[VAL_W-1:BIT_W];
  assign img_bit   = rd_r[BIT_W-1:0];
  assign img_oor   = ({1'b0, img_word} >= wc_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid_i && q_head_i.kind == CMD_APPLY) state_nxt = BK_WALK;
      end
      BK_WALK: begin
        if (elem_last) state_nxt = BK_DRAIN;
      end
      BK_DRAIN: begin
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        if (w_last) state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (w_last) state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control strobes.
  always_comb begin
    q_pop_o    = 1'b0;
    do_perm_wr = 1'b0;
    do_set_wr  = 1'b0;
    do_apply   = 1'b0;
    do_proc    = 1'b0;
    do_check   = 1'b0;
    do_emit    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop_o    = q_valid_i;
        do_perm_wr = q_valid_i && (q_head_i.kind == CMD_PERM);
        do_set_wr  = q_valid_i && (q_head_i.kind == CMD_SET);
        do_apply   = q_valid_i && (q_head_i.kind == CMD_APPLY);
      end
      BK_WALK, BK_DRAIN: begin
        do_proc = pend_v_r;
      end
      BK_CHECK: begin
        do_check = 1'b1;
      end
      BK_EMIT: begin
        do_emit = 1'b1;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_v_r    <= 1'b0;
      closed_r    <= 1'b1;
      out_valid_r <= 1'b0;
      wc_r        <= WC_W'(1);
      e_r         <= '0;
      w_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= (state_r == BK_WALK) && member;
      out_valid_r <= do_emit;
      if (do_apply) begin
        wc_r     <= wc_use;
        e_r      <= '0;
        closed_r <= 1'b1;
      end else if (state_r == BK_WALK) begin
        e_r <= e_r + ELEM_W'(1);
      end
      if (do_proc && img_oor) closed_r <= 1'b0;
      if (do_check && |(image_r[w_r] & ~set_rd)) closed_r <= 1'b0;
      if (state_r == BK_DRAIN || (do_check && w_last)) begin
        w_r <= '0;
      end else if (do_check || do_emit) begin
        w_r <= w_r + WIDX_W'(1);
      end
    end
  end

  // Permutation table: one write port, registered read of the walked element.
  always_ff @(posedge clk) begin
    if (do_perm_wr) perm_mem[q_head_i.index] <= q_head_i.image_value;
    rd_r <= perm_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (do_set_wr) set_r[q_head_i.index[WIDX_W-1:0]] <= q_head_i.set_word;
  end

  // Image store: clear on apply, OR in each in-range image.
  always_ff @(posedge clk) begin
    if (do_apply) begin
      for (int i = 0; i < SET_WORDS; i++) image_r[i] <= '0;
    end else if (do_proc && !img_oor) begin
      image_r[img_word][~img_bit] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_word_index_r <= w_r;
      out_image_word_r <= image_r[w_r];
      out_flag_r       <= closed_r;
      out_last_r       <= w_last;
    end
  end

  assign out_valid_o            = out_valid_r;
  assign out_word_index_o       = out_word_index_r;
  assign out_image_word_o       = out_image_word_r;
  assign out_maps_into_itself_o = out_flag_r;
  assign out_last_o             = out_last_r;

endmodule

`default_nettype wire

// ===== sv/bitset_permutation_image.sv =====
// Top level of the bit set permutation image block.
// Depends on bpi_pkg, bpi_front and bpi_back.
//
// Usage:
//   Input channel: drive in_op/in_index/in_image_value/in_set_word with start;
//   a beat is taken at an edge where start is high and busy is low. Op 0
//   writes one permutation entry, op 1 one set word, op 2 applies the
//   permutation to the set and emits the image. Op 3 and set loads with an
//   index beyond the store are dropped.
//   Config channel: cfg_word_count is written when cfg_valid is high
//   (cfg_ready is always high); write it only while the block is idle.
//   Result channel: out_valid marks each result beat for one cycle; the
//   receiver cannot stall, so take every beat as it comes.
// Timing:
//   Loads stream through the two-entry command queue at one per cycle
//   while the back end is idle. An apply walks every element of the words
//   in use, one per cycle through the permutation table's read port; with W
//   words in use it then checks the image and emits W result beats.
//   Intake continues until the queue fills.
// Reset: synchronous, active low; clears the queue and the sequencer and
//   sets the word count to 1. Table and set contents stay undefined.
`default_nettype none

module bitset_permutation_image (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bpi_pkg::OP_W-1:0]       in_op,
  input  wire logic [bpi_pkg::VAL_W-1:0]      in_index,
  input  wire logic [bpi_pkg::VAL_W-1:0]      in_image_value,
  input  wire logic [bpi_pkg::WORD_BITS-1:0]  in_set_word,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bpi_pkg::WC_W-1:0]       cfg_word_count,
  output logic                                out_valid,
  output logic [bpi_pkg::WIDX_W-1:0]          out_word_index,
  output logic [bpi_pkg::WORD_BITS-1:0]       out_image_word,
  output logic                                out_maps_into_itself,
  output logic                                out_last
);
  import bpi_pkg::*;

  logic [WC_W-1:0] word_count_r;
  cmd_t            q_head;
  logic            q_valid;
  logic            q_pop;

  // Config register: always ready, hold until the next write beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= WC_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      word_count_r <= cfg_word_count;
    end
  end

  // Front: take beats, drop the ones without effect, queue the rest.
  bpi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op_i          (in_op),
    .index_i       (in_index),
    .image_value_i (in_image_value),
    .set_word_i    (in_set_word),
    .q_head_o      (q_head),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop)
  );

  // Back: advance one queued command at a time; applies walk and emit.
  bpi_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .word_count_i           (word_count_r),
    .q_head_i               (q_head),
    .q_valid_i              (q_valid),
    .q_pop_o                (q_pop),
    .out_valid_o            (out_valid),
    .out_word_index_o       (out_word_index),
    .out_image_word_o       (out_image_word),
    .out_maps_into_itself_o (out_maps_into_itself),
    .out_last_o             (out_last)
  );

endmodule

`default_nettype wire
